// ===== design/lockstep_input_exchange_unit_defines.svh =====
// Assertion macros shared by the lockstep input exchange checker.
`ifndef LOCKSTEP_INPUT_EXCHANGE_UNIT_DEFINES_SVH
`define LOCKSTEP_INPUT_EXCHANGE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define LIEU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define LIEU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lieu_pkg.sv =====
// Shared types and constants for the lockstep input exchange unit.
package lieu_pkg;

	localparam int unsigned RING_DEPTH_DEF = 64;
	localparam int unsigned MAX_RESEND     = 16;

	localparam int unsigned FRAME_W    = 32;
	localparam int unsigned MASK_W     = 16;
	localparam int unsigned DELAY_W    = 5;
	localparam int unsigned WINDOW_W   = 5;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 5;

	localparam logic [FRAME_W-1:0]  TAG_EMPTY    = 32'hFFFF_FFFF;
	localparam logic [DELAY_W-1:0]  DELAY_RESET  = 5'd5;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd16;

	localparam logic MODE_PACKET = 1'b0;
	localparam logic MODE_STEP   = 1'b1;

	localparam logic KIND_PACKET   = 1'b0;
	localparam logic KIND_DECISION = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_DELAY,
		CFG_RESEND_WINDOW,
		CFG_LOCAL_PLAYER,
		CFG_PEER_CONFIGURED
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_GATE
	} seq_state_t;

	typedef struct packed {
		logic [FRAME_W-1:0] tag;
		logic [MASK_W-1:0]  mask;
	} entry_t;

endpackage

// ===== design/lieu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lieu_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/lockstep_input_exchange_unit.sv =====
// Lockstep input exchange: remote and sent input rings with a resend and gate sequencer.
//
// Items enter on item_valid/item_stall; a beat is taken when valid is high and stall low.
// A remote packet beat (mode 0) is written into the remote ring in the cycle it is taken
// and gives no result; the block can take another beat in the next cycle.
// A frame step beat (mode 1) stores the local mask at current frame plus input delay and
// keeps item_stall high while the sequencer runs: a setup state, then a scan that reads
// one entry of the resend window per cycle through the single read port of the sent ring,
// holding while a matching entry waits for a free output slot, then a gate state. The scan
// is skipped when the peer is not yet usable. It gives one result beat per matching sent
// entry and a closing decision beat with last set.
// Results leave through one output register on result_valid/result_stall. While the
// receiver stalls, the sequencer waits on the next beat it has to hand over.
// Configuration writes use cfg_valid/cfg_ready; cfg_ready is always high.
// After reset a clearing pass, during which item_stall is high, empties the remote ring
// and primes the sent ring. Writing input_delay while the frame counter is zero restarts
// a pass over the sent ring. RING_DEPTH must be a power of two.
module lockstep_input_exchange_unit import lieu_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  mode,
	input  logic [FRAME_W-1:0]    remote_frame,
	input  logic [MASK_W-1:0]     input_mask,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  kind,
	output logic [FRAME_W-1:0]    packet_frame,
	output logic [MASK_W-1:0]     packet_mask,
	output logic [MASK_W-1:0]     player_one_mask,
	output logic [MASK_W-1:0]     player_two_mask,
	output logic                  advanced,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned EW = FRAME_W + MASK_W;

	logic [DELAY_W-1:0]  delay_q;
	logic [WINDOW_W-1:0] window_q;
	logic                local_player_q;
	logic                peer_cfg_q;
	logic                peer_known_q;
	logic [FRAME_W-1:0]  cur_q;
	logic [FRAME_W-1:0]  target_q;
	logic [FRAME_W-1:0]  f_q;
	logic [FRAME_W-1:0]  f_d;
	seq_state_t          state_q;
	seq_state_t          state_d;

	logic                sweep_q;
	logic                clr_remote_q;
	logic [AW-1:0]       sweep_idx_q;
	logic                sweep_start;

	logic                item_acc;
	logic                cfg_we;
	logic [FRAME_W-1:0]  target_c;
	logic [FRAME_W-1:0]  start_c;
	logic [5:0]          win_eff;
	logic [5:0]          win_m1;
	logic                peer_usable;

	logic                sent_we;
	logic [AW-1:0]       sent_waddr;
	entry_t              sent_wdata;
	logic                sent_re;
	logic [AW-1:0]       sent_raddr;
	entry_t              sent_rd;
	logic                rem_we;
	logic [AW-1:0]       rem_waddr;
	entry_t              rem_wdata;
	logic                rem_re;
	logic [AW-1:0]       rem_raddr;
	entry_t              rem_rd;
	logic [FRAME_W-1:0]  prime_tag;

	logic                out_free;
	logic                load_out;
	logic                adv_en;
	logic                nx_kind;
	logic [FRAME_W-1:0]  nx_frame;
	logic [MASK_W-1:0]   nx_pmask;
	logic [MASK_W-1:0]   nx_p1;
	logic [MASK_W-1:0]   nx_p2;
	logic                nx_adv;
	logic                hit;
	logic                res_valid_q;

	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid;
	assign item_stall  = (state_q != ST_IDLE) || sweep_q;
	assign item_acc    = item_valid && !item_stall;
	assign target_c    = cur_q + FRAME_W'(delay_q);
	assign peer_usable = peer_cfg_q || peer_known_q;
	assign sweep_start = cfg_we && (cfg_idx_t'(cfg_index) == CFG_INPUT_DELAY) && (cur_q == '0);

	// Clamp the resend window to 1..MAX_RESEND and find where it starts.
	always_comb begin
		if (window_q == '0) begin
			win_eff = 6'd1;
		end else if ({1'b0, window_q} > 6'(MAX_RESEND)) begin
			win_eff = 6'(MAX_RESEND);
		end else begin
			win_eff = {1'b0, window_q};
		end
		win_m1 = win_eff - 6'd1;
		if (target_q >= FRAME_W'(win_m1)) begin
			start_c = target_q - FRAME_W'(win_m1);
		end else begin
			start_c = '0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q        <= DELAY_RESET;
			window_q       <= WINDOW_RESET;
			local_player_q <= 1'b0;
			peer_cfg_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INPUT_DELAY: begin
					delay_q <= cfg_data[DELAY_W-1:0];
				end
				CFG_RESEND_WINDOW: begin
					window_q <= cfg_data[WINDOW_W-1:0];
				end
				CFG_LOCAL_PLAYER: begin
					local_player_q <= cfg_data[0];
				end
				CFG_PEER_CONFIGURED: begin
					peer_cfg_q <= cfg_data[0];
				end
			endcase
		end
	end

	// Clearing pass: the sent ring is primed with its first input_delay frames, and
	// the remote ring is emptied only on the pass that follows reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			clr_remote_q <= 1'b1;
			sweep_idx_q  <= '0;
		end else if (sweep_start) begin
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
		end else if (sweep_q) begin
			if (sweep_idx_q == AW'(RING_DEPTH - 1)) begin
				sweep_q      <= 1'b0;
				clr_remote_q <= 1'b0;
			end else begin
				sweep_idx_q <= sweep_idx_q + AW'(1);
			end
		end
	end

	assign prime_tag = (sweep_idx_q < AW'(delay_q)) ? FRAME_W'(sweep_idx_q) : TAG_EMPTY;

	always_comb begin
		if (sweep_q) begin
			sent_we    = 1'b1;
			sent_waddr = sweep_idx_q;
			sent_wdata = '{tag: prime_tag, mask: '0};
		end else begin
			sent_we    = item_acc && (mode == MODE_STEP);
			sent_waddr = target_c[AW-1:0];
			sent_wdata = '{tag: target_c, mask: input_mask};
		end
		if (sweep_q) begin
			rem_we    = clr_remote_q;
			rem_waddr = sweep_idx_q;
			rem_wdata = '{tag: TAG_EMPTY, mask: '0};
		end else begin
			rem_we    = item_acc && (mode == MODE_PACKET);
			rem_waddr = remote_frame[AW-1:0];
			rem_wdata = '{tag: remote_frame, mask: input_mask};
		end
	end

	lieu_ram #(
		.WIDTH (EW),
		.DEPTH (RING_DEPTH)
	) u_sent_ram (
		.clk   (clk),
		.we    (sent_we),
		.waddr (sent_waddr),
		.wdata (sent_wdata),
		.re    (sent_re),
		.raddr (sent_raddr),
		.rdata (sent_rd)
	);

	lieu_ram #(
		.WIDTH (EW),
		.DEPTH (RING_DEPTH)
	) u_remote_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.re    (rem_re),
		.raddr (rem_raddr),
		.rdata (rem_rd)
	);

	assign out_free = !res_valid_q || !result_stall;
	assign hit      = (sent_rd.tag == cur_q) && (rem_rd.tag == cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		f_d        = f_q;
		sent_re    = 1'b0;
		sent_raddr = cur_q[AW-1:0];
		rem_re     = 1'b0;
		rem_raddr  = cur_q[AW-1:0];
		load_out   = 1'b0;
		adv_en     = 1'b0;
		nx_kind    = KIND_PACKET;
		nx_frame   = f_q;
		nx_pmask   = sent_rd.mask;
		nx_p1      = '0;
		nx_p2      = '0;
		nx_adv     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc && (mode == MODE_STEP)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				sent_re = 1'b1;
				if (peer_usable) begin
					sent_raddr = start_c[AW-1:0];
					f_d        = start_c;
					state_d    = ST_SCAN;
				end else begin
					rem_re  = 1'b1;
					state_d = ST_GATE;
				end
			end
			ST_SCAN: begin
				// The read data belongs to frame f_q; a match waits for a free output slot.
				if ((sent_rd.tag != f_q) || out_free) begin
					load_out = (sent_rd.tag == f_q);
					sent_re  = 1'b1;
					if (f_q == target_q) begin
						rem_re  = 1'b1;
						state_d = ST_GATE;
					end else begin
						f_d        = f_q + FRAME_W'(1);
						sent_raddr = f_d[AW-1:0];
					end
				end
			end
			ST_GATE: begin
				nx_kind  = KIND_DECISION;
				nx_frame = cur_q;
				nx_pmask = '0;
				if (hit) begin
					nx_adv = 1'b1;
					nx_p1  = local_player_q ? rem_rd.mask : sent_rd.mask;
					nx_p2  = local_player_q ? sent_rd.mask : rem_rd.mask;
				end
				if (out_free) begin
					load_out = 1'b1;
					adv_en   = hit;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= '0;
			peer_known_q <= 1'b0;
		end else begin
			if (adv_en) begin
				cur_q <= cur_q + FRAME_W'(1);
			end
			if (item_acc && (mode == MODE_PACKET)) begin
				peer_known_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		f_q <= f_d;
		if (item_acc) begin
			target_q <= target_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind            <= nx_kind;
			packet_frame    <= nx_frame;
			packet_mask     <= nx_pmask;
			player_one_mask <= nx_p1;
			player_two_mask <= nx_p2;
			advanced        <= nx_adv;
			last            <= nx_kind;
		end
	end

	assign result_valid = res_valid_q;

endmodule

// ===== design/lieu_checker.sv =====
// Port-level checker for the lockstep input exchange unit, bound to the top level.
`include "lockstep_input_exchange_unit_defines.svh"

module lieu_checker import lieu_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input logic                  mode,
	input logic [FRAME_W-1:0]    remote_frame,
	input logic [MASK_W-1:0]     input_mask,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic                  kind,
	input logic [FRAME_W-1:0]    packet_frame,
	input logic [MASK_W-1:0]     packet_mask,
	input logic [MASK_W-1:0]     player_one_mask,
	input logic [MASK_W-1:0]     player_two_mask,
	input logic                  advanced,
	input logic                  last,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A stalled result beat keeps its contents.
	`LIEU_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(packet_frame) && $stable(kind) && $stable(packet_mask), "stalled result beat changed")

	// A frame step keeps the block busy in the following cycle.
	`LIEU_ASSERT_NEXT(a_step_busy, item_valid && !item_stall && mode == MODE_STEP, item_stall, "block took a beat right after a frame step")

	// Only the decision closes a step.
	`LIEU_ASSERT_NOW(a_last_is_decision, result_valid, last == (kind == KIND_DECISION), "last does not match result kind")

	// Packets never advance, and no beat that has not advanced carries player masks.
	`LIEU_ASSERT_NOW(a_packet_no_adv, result_valid && kind == KIND_PACKET, !advanced, "packet beat marked advanced")

	`LIEU_ASSERT_NOW(a_wait_no_masks, result_valid && !advanced, player_one_mask == '0 && player_two_mask == '0, "waiting beat carries player masks")

endmodule

bind lockstep_input_exchange_unit lieu_checker u_lieu_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the lockstep input exchange unit.
`timescale 1ns / 1ps

module tb_top;
	import lieu_pkg::*;

	localparam int unsigned DEPTH       = RING_DEPTH_DEF;
	localparam int unsigned ITEMS       = 480;
	localparam int unsigned QUIET       = 24;
	localparam int unsigned TAIL        = 40;
	localparam int unsigned LONG_HOLD   = 200;
	localparam int unsigned HOLD_AFTER  = 150;
	localparam int unsigned MAX_REPORTS = 40;

	typedef struct packed {
		logic               mode;
		logic [FRAME_W-1:0] rframe;
		logic [MASK_W-1:0]  mask;
	} exchange_item_t;

	typedef struct packed {
		logic               kind;
		logic [FRAME_W-1:0] frame;
		logic [MASK_W-1:0]  pmask;
		logic [MASK_W-1:0]  p1;
		logic [MASK_W-1:0]  p2;
		logic               adv;
		logic               last;
	} exchange_beat_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	logic                  mode         = MODE_PACKET;
	logic [FRAME_W-1:0]    remote_frame = '0;
	logic [MASK_W-1:0]     input_mask   = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  kind;
	logic [FRAME_W-1:0]    packet_frame;
	logic [MASK_W-1:0]     packet_mask;
	logic [MASK_W-1:0]     player_one_mask;
	logic [MASK_W-1:0]     player_two_mask;
	logic                  advanced;
	logic                  last;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Shadow copy of the exchange state.
	logic [FRAME_W-1:0]  frame_now;
	logic [FRAME_W-1:0]  remote_tag [DEPTH];
	logic [MASK_W-1:0]   remote_mask[DEPTH];
	logic [FRAME_W-1:0]  sent_tag   [DEPTH];
	logic [MASK_W-1:0]   sent_mask  [DEPTH];
	bit                  peer_seen;
	logic [DELAY_W-1:0]  delay_reg;
	logic [WINDOW_W-1:0] window_reg;
	bit                  player_reg;
	bit                  peer_cfg_reg;

	exchange_item_t pending_items[$];
	exchange_beat_t expected_beats[$];
	exchange_item_t item_on_bus;

	int unsigned mismatches    = 0;
	int unsigned items_queued  = 0;
	int unsigned random_start  = 0;
	int unsigned tx_gap        = 0;
	int unsigned rx_wait       = 0;
	int unsigned hold_left     = 0;
	bit          calm          = 1'b0;
	bit          hold_req      = 1'b0;
	bit          hold_taken    = 1'b0;

	lockstep_input_exchange_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.mode            (mode),
		.remote_frame    (remote_frame),
		.input_mask      (input_mask),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.kind            (kind),
		.packet_frame    (packet_frame),
		.packet_mask     (packet_mask),
		.player_one_mask (player_one_mask),
		.player_two_mask (player_two_mask),
		.advanced        (advanced),
		.last            (last),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int ring_slot(input logic [FRAME_W-1:0] f);
		return int'(f % DEPTH);
	endfunction

	function automatic void prime_sent_ring();
		int i;
		for (i = 0; i < DEPTH; i++) begin
			sent_tag[i]  = TAG_EMPTY;
			sent_mask[i] = '0;
		end
		for (i = 0; i < delay_reg; i++)
			sent_tag[ring_slot(i)] = i;
	endfunction

	function automatic void reset_exchange();
		int i;
		delay_reg    = DELAY_RESET;
		window_reg   = WINDOW_RESET;
		player_reg   = 1'b0;
		peer_cfg_reg = 1'b0;
		frame_now    = '0;
		peer_seen    = 1'b0;
		for (i = 0; i < DEPTH; i++) begin
			remote_tag[i]  = TAG_EMPTY;
			remote_mask[i] = '0;
		end
		prime_sent_ring();
	endfunction

	function automatic void apply_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_INPUT_DELAY: begin
				delay_reg = d[DELAY_W-1:0];
				if (frame_now == 0)
					prime_sent_ring();
			end
			CFG_RESEND_WINDOW:   window_reg   = d[WINDOW_W-1:0];
			CFG_LOCAL_PLAYER:    player_reg   = d[0];
			CFG_PEER_CONFIGURED: peer_cfg_reg = d[0];
			default: ;
		endcase
	endfunction

	// Expected beats: none for a packet; for a step, resent packets, then the decision.
	function automatic void exchange_step(input exchange_item_t it);
		logic [FRAME_W-1:0] target;
		logic [FRAME_W-1:0] start;
		logic [FRAME_W-1:0] f;
		logic [FRAME_W-1:0] count;
		int unsigned        win;
		int unsigned        k;
		int                 s;
		exchange_beat_t     b;
		if (it.mode == MODE_PACKET) begin
			s = ring_slot(it.rframe);
			remote_tag[s]  = it.rframe;
			remote_mask[s] = it.mask;
			peer_seen      = 1'b1;
			return;
		end
		target = frame_now + delay_reg;
		s = ring_slot(target);
		sent_tag[s]  = target;
		sent_mask[s] = it.mask;
		if (peer_cfg_reg || peer_seen) begin
			win = window_reg;
			if (win < 1)
				win = 1;
			if (win > MAX_RESEND)
				win = MAX_RESEND;
			start = (target >= win - 1) ? target - (win - 1) : '0;
			count = target - start + 1;
			for (k = 0; k < count; k++) begin
				f = start + k;
				s = ring_slot(f);
				if (sent_tag[s] == f) begin
					b = '{KIND_PACKET, f, sent_mask[s], '0, '0, 1'b0, 1'b0};
					expected_beats.push_back(b);
				end
			end
		end
		s = ring_slot(frame_now);
		if (remote_tag[s] == frame_now && sent_tag[s] == frame_now) begin
			if (!player_reg)
				b = '{KIND_DECISION, frame_now, '0, sent_mask[s], remote_mask[s], 1'b1, 1'b1};
			else
				b = '{KIND_DECISION, frame_now, '0, remote_mask[s], sent_mask[s], 1'b1, 1'b1};
			frame_now = frame_now + 1;
		end else begin
			b = '{KIND_DECISION, frame_now, '0, '0, '0, 1'b0, 1'b1};
		end
		expected_beats.push_back(b);
	endfunction

	// Number of consecutive frames from the current one that already hold a local mask.
	function automatic int unsigned frames_ready();
		int unsigned n;
		n = 0;
		while (n < 31 && sent_tag[ring_slot(frame_now + n)] == frame_now + n)
			n++;
		return n;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function automatic void push_item(input logic m, input logic [FRAME_W-1:0] fr,
			input logic [MASK_W-1:0] mk);
		exchange_item_t it;
		it = '{m, fr, mk};
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic logic [MASK_W-1:0] rand_mask();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return MASK_W'($urandom);
		endcase
	endfunction

	function automatic logic [WINDOW_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0:       return 5'd0;
			1:       return 5'd1;
			2:       return 5'd16;
			3:       return 5'd17;
			4:       return 5'd31;
			default: return WINDOW_W'($urandom_range(0, 31));
		endcase
	endfunction

	// Item driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (item_valid && !item_stall)
				exchange_step(item_on_bus);
			if (!item_valid || !item_stall) begin
				if (tx_gap != 0) begin
					tx_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item_on_bus = pending_items.pop_front();
					item_valid   <= 1'b1;
					mode         <= item_on_bus.mode;
					remote_frame <= item_on_bus.rframe;
					input_mask   <= item_on_bus.mask;
					tx_gap = calm ? 0 : $urandom_range(0, 3);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold, armed once the random traffic is under way.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= LONG_HOLD;
		end
	end

	// Result monitor and receiver stall.
	always @(posedge clk or negedge arst_n) begin
		exchange_beat_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_wait   = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$error("result beat with nothing expected, frame %0h", packet_frame);
				end else begin
					want = expected_beats.pop_front();
					compare_field("kind", 32'(want.kind), 32'(kind));
					compare_field("packet_frame", want.frame, packet_frame);
					compare_field("packet_mask", 32'(want.pmask), 32'(packet_mask));
					compare_field("player_one_mask", 32'(want.p1), 32'(player_one_mask));
					compare_field("player_two_mask", 32'(want.p2), 32'(player_two_mask));
					compare_field("advanced", 32'(want.adv), 32'(advanced));
					compare_field("last", 32'(want.last), 32'(last));
				end
				rx_wait = calm ? 0 : $urandom_range(0, 3);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			result_stall <= (rx_wait != 0) || (hold_left != 0);
		end
	end

	task automatic await_drain();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid)
			@(negedge clk);
	endtask

	task automatic settle(input int unsigned cycles);
		await_drain();
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_register(idx, d);
		cfg_valid <= 1'b0;
	endtask

	// Raising the delay at a nonzero frame leaves a hole ahead of the frame. Fill it first:
	// one step per delay value, high to low, while the remote entry is parked.
	task automatic raise_delay(input int unsigned goal);
		int k;
		push_item(MODE_PACKET, frame_now + DEPTH, rand_mask());
		for (k = goal; k >= 1; k--) begin
			settle(QUIET);
			write_reg(CFG_INPUT_DELAY, CFG_DATA_W'(k));
			push_item(MODE_STEP, $urandom, rand_mask());
		end
		settle(QUIET);
		write_reg(CFG_INPUT_DELAY, 0);
		push_item(MODE_PACKET, frame_now, rand_mask());
		push_item(MODE_STEP, $urandom, rand_mask());
		settle(QUIET);
		write_reg(CFG_INPUT_DELAY, CFG_DATA_W'(goal));
	endtask

	task automatic gen_burst();
		logic [FRAME_W-1:0] cur;
		int unsigned        pick;
		await_drain();
		cur  = frame_now;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			push_item(MODE_PACKET, cur, rand_mask());
			if ($urandom_range(0, 1))
				push_item(MODE_PACKET, cur + $urandom_range(1, 3), rand_mask());
			push_item(MODE_STEP, $urandom, rand_mask());
		end else if (pick == 6) begin
			push_item(MODE_STEP, $urandom, rand_mask());
		end else if (pick == 7) begin
			push_item(MODE_PACKET, $urandom, rand_mask());
		end else if (pick == 8) begin
			push_item(MODE_PACKET, cur - $urandom_range(0, 70), rand_mask());
		end else begin
			push_item(MODE_PACKET, cur + $urandom_range(4, 100), rand_mask());
			push_item(MODE_STEP, $urandom, rand_mask());
		end
		if (items_queued - random_start >= HOLD_AFTER)
			hold_req = 1'b1;
	endtask

	initial begin
		int unsigned phase;
		int unsigned d;
		phase = 0;
		reset_exchange();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Leave room for the clearing pass that follows reset.
		settle(DEPTH + 8);

		// Peer not usable yet: the step gives only a decision beat.
		push_item(MODE_STEP, 32'h0, 16'hFFFF);
		settle(QUIET);
		write_reg(CFG_PEER_CONFIGURED, 1);
		// Window clipped at frame zero.
		push_item(MODE_STEP, 32'hFFFF_FFFF, 16'h1234);
		settle(QUIET);
		// Largest delay primed at frame zero: a full window of resent packets.
		write_reg(CFG_INPUT_DELAY, 31);
		push_item(MODE_STEP, 32'h5555_5555, 16'h0000);
		settle(QUIET);
		write_reg(CFG_PEER_CONFIGURED, 0);
		write_reg(CFG_INPUT_DELAY, 0);
		// The first remote beat makes the peer known.
		push_item(MODE_PACKET, 32'd0, 16'hFFFF);
		push_item(MODE_STEP, 32'hAAAA_AAAA, 16'hA5A5);
		settle(QUIET);
		write_reg(CFG_LOCAL_PLAYER, 1);
		push_item(MODE_PACKET, 32'd1, 16'h0000);
		push_item(MODE_STEP, 32'h0, 16'hFFFF);
		settle(QUIET);
		write_reg(CFG_RESEND_WINDOW, 0);
		push_item(MODE_PACKET, 32'd2, 16'h5A5A);
		push_item(MODE_STEP, 32'h0, 16'h0F0F);
		settle(QUIET);
		// Window above the maximum, and a delay raised past the stored frames.
		write_reg(CFG_RESEND_WINDOW, 31);
		write_reg(CFG_INPUT_DELAY, 31);
		push_item(MODE_PACKET, 32'd3, 16'h3C3C);
		push_item(MODE_STEP, 32'h0, 16'hC3C3);
		push_item(MODE_STEP, 32'h0, 16'h8001);
		settle(QUIET);
		write_reg(CFG_INPUT_DELAY, 0);
		push_item(MODE_STEP, 32'h0, 16'h7FFE);
		// An all-ones frame lands on an empty entry with the same tag.
		push_item(MODE_PACKET, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(MODE_PACKET, 32'h7FFF_FFFF, 16'h1357);
		push_item(MODE_PACKET, 32'h8000_0000, 16'h2468);
		push_item(MODE_STEP, 32'h0, 16'h0001);
		push_item(MODE_PACKET, 32'd4, 16'hBEEF);
		push_item(MODE_STEP, 32'h0, 16'h0002);

		random_start = items_queued;
		while (items_queued - random_start < ITEMS) begin
			phase++;
			settle(QUIET);
			calm = (phase % 5 == 3);
			if (phase % 4 == 1) begin
				raise_delay((phase == 1) ? 31 : $urandom_range(1, 31));
			end else begin
				// Mostly a delay the stored frames can carry; now and then any delay.
				d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
					: $urandom_range(0, frames_ready());
				write_reg(CFG_INPUT_DELAY, CFG_DATA_W'(d));
			end
			write_reg(CFG_RESEND_WINDOW, pick_window());
			write_reg(CFG_LOCAL_PLAYER, CFG_DATA_W'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_PEER_CONFIGURED, CFG_DATA_W'($urandom_range(0, 1)));
			repeat ($urandom_range(8, 20)) gen_burst();
		end

		settle(TAIL);
		if (expected_beats.size() != 0) begin
			mismatches++;
			$error("%0d result beats never arrived", expected_beats.size());
		end
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
